>>> rtl/afc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the aspect fit contain block
// Field widths, operation and status codes, and the records that travel
// through the front end, the divider cells and the back end.
// ----------------------------------------------------------------------------
package afc_pkg;

	// extent and scale format
	localparam int EXTENT_BITS     = 16;
	localparam int SCALE_FRAC_BITS = 16;
	localparam int FUNC_W          = 3;
	localparam int STATUS_W        = 2;
	localparam int SCALE_W         = 32;
	localparam int OFS_W           = EXTENT_BITS - 1;
	localparam int PROD_W          = 2 * EXTENT_BITS;

	// dividend must hold a product of two extents or a scale numerator
	localparam int DVD_W = EXTENT_BITS +
		((EXTENT_BITS > SCALE_FRAC_BITS) ? EXTENT_BITS : SCALE_FRAC_BITS);
	// rounded quotient, one bit of headroom for the round-up
	localparam int QR_W  = DVD_W + 1;
	// one divider cell per quotient bit
	localparam int NUM_CELLS = DVD_W;

	// divider lanes: width (or ratio result), height, scale
	localparam int NUM_LANES = 3;
	localparam int LANE_W    = 0;
	localparam int LANE_H    = 1;
	localparam int LANE_S    = 2;

	// stream payload sizes
	localparam int IN_FIELDS_W  = 5 * EXTENT_BITS + 1;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_USER_W    = 8;
	localparam int OUT_FIELDS_W = SCALE_W + 2 * EXTENT_BITS + 2 * OFS_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_USER_W   = 8;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_SCALE = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SIZE  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_RECT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_WFH   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_HFW   = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_SRC   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_BOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd3;

	typedef logic [EXTENT_BITS-1:0] ext_t;

	// one fit request as it enters
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		ext_t              sw;
		ext_t              sh;
		ext_t              bw;
		ext_t              bh;
		logic              up;
		ext_t              g;
	} req_t;

	// control carried alongside the divider lanes
	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic                func_ok;
		logic [STATUS_W-1:0] status;
		ext_t                bw;
		ext_t                bh;
	} side_t;

	// state of one restoring divider lane
	typedef struct packed {
		ext_t             dsr;
		ext_t             rem;
		logic [DVD_W-1:0] dvd;
		logic [DVD_W-1:0] quo;
	} lane_t;

	// contents of one divider cell
	typedef struct packed {
		side_t                   side;
		lane_t [NUM_LANES-1:0]   lane;
	} cell_t;

	// one result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SCALE_W-1:0]  scale;
		ext_t                out_width;
		ext_t                out_height;
		logic [OFS_W-1:0]    offset_x;
		logic [OFS_W-1:0]    offset_y;
	} res_t;

endpackage

>>> rtl/afc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_front: request preparation
// Registers the request, forms the cross products, picks the limiting ratio
// and loads the three divider lanes with dividends and divisors.
// ----------------------------------------------------------------------------
module afc_front
	import afc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  req_t  in_req,
	output logic  out_valid,
	output cell_t out_cell
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	req_t        req_s1, req_s2, req_s3;
	logic [PROD_W-1:0] pa_s2, pb_s2;
	ext_t        num_s3, den_s3;
	logic [STATUS_W-1:0] status_s3;
	logic        func_ok_s3;
	cell_t       cell_s4;

	logic        le;
	logic        up_eff;
	ext_t        num_sel, den_sel;
	ext_t        num_c, den_c;
	logic [STATUS_W-1:0] status_c;
	logic        ratio;
	ext_t        mul_a, mul_b, dsr0;
	logic [PROD_W-1:0] prod0, prod1;
	cell_t       cell_c;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// limiting ratio, upscale cap and early status
	always_comb begin
		le      = (pa_s2 <= pb_s2);
		num_sel = le ? req_s2.bw : req_s2.bh;
		den_sel = le ? req_s2.sw : req_s2.sh;
		up_eff  = req_s2.up || (req_s2.func == FN_RECT);
		if (!up_eff && (num_sel > den_sel)) begin
			num_c = EXTENT_BITS'(1);
			den_c = EXTENT_BITS'(1);
		end else begin
			num_c = num_sel;
			den_c = den_sel;
		end
		if ((req_s2.sw == '0) || (req_s2.sh == '0))
			status_c = ST_ZERO_SRC;
		else if ((req_s2.func == FN_WFH) || (req_s2.func == FN_HFW))
			status_c = ST_OK;
		else if ((req_s2.bw == '0) || (req_s2.bh == '0))
			status_c = ST_ZERO_BOUND;
		else
			status_c = ST_OK;
	end

	// lane operands: width lane also serves the two ratio operations
	always_comb begin
		ratio = (req_s3.func == FN_WFH) || (req_s3.func == FN_HFW);
		mul_a = ratio ? req_s3.g : num_s3;
		mul_b = ratio ? ((req_s3.func == FN_WFH) ? req_s3.sw : req_s3.sh) : req_s3.sw;
		dsr0  = ratio ? ((req_s3.func == FN_WFH) ? req_s3.sh : req_s3.sw) : den_s3;
		prod0 = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod1 = PROD_W'(req_s3.sh) * PROD_W'(num_s3);

		cell_c.side.func    = req_s3.func;
		cell_c.side.func_ok = func_ok_s3;
		cell_c.side.status  = status_s3;
		cell_c.side.bw      = req_s3.bw;
		cell_c.side.bh      = req_s3.bh;

		cell_c.lane[LANE_W].dsr = dsr0;
		cell_c.lane[LANE_W].rem = '0;
		cell_c.lane[LANE_W].dvd = DVD_W'(prod0);
		cell_c.lane[LANE_W].quo = '0;

		cell_c.lane[LANE_H].dsr = den_s3;
		cell_c.lane[LANE_H].rem = '0;
		cell_c.lane[LANE_H].dvd = DVD_W'(prod1);
		cell_c.lane[LANE_H].quo = '0;

		cell_c.lane[LANE_S].dsr = den_s3;
		cell_c.lane[LANE_S].rem = '0;
		cell_c.lane[LANE_S].dvd = DVD_W'(num_s3) << SCALE_FRAC_BITS;
		cell_c.lane[LANE_S].quo = '0;
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			req_s1     <= in_req;
			req_s2     <= req_s1;
			pa_s2      <= PROD_W'(req_s1.bw) * PROD_W'(req_s1.sh);
			pb_s2      <= PROD_W'(req_s1.bh) * PROD_W'(req_s1.sw);
			req_s3     <= req_s2;
			num_s3     <= num_c;
			den_s3     <= den_c;
			status_s3  <= status_c;
			func_ok_s3 <= (req_s2.func <= FN_HFW);
			cell_s4    <= cell_c;
		end
	end

	assign out_valid = valid_s4;
	assign out_cell  = cell_s4;

endmodule

>>> rtl/afc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_cell: one divider cell
// Takes one restoring division step on each of the three lanes and hands
// the partial quotients and remainders to the next cell.
// ----------------------------------------------------------------------------
module afc_cell
	import afc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  cell_t in_cell,
	output logic  out_valid,
	output cell_t out_cell
);

	logic  valid_q;
	cell_t cell_q;
	cell_t nxt;
	logic [EXTENT_BITS:0] shifted [NUM_LANES];
	logic [EXTENT_BITS:0] diff    [NUM_LANES];
	logic                 take    [NUM_LANES];

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		nxt.side = in_cell.side;
		for (int l = 0; l < NUM_LANES; l++) begin
			shifted[l] = {in_cell.lane[l].rem, in_cell.lane[l].dvd[DVD_W-1]};
			diff[l]    = shifted[l] - {1'b0, in_cell.lane[l].dsr};
			take[l]    = !diff[l][EXTENT_BITS];
			nxt.lane[l].dsr = in_cell.lane[l].dsr;
			nxt.lane[l].rem = take[l] ? diff[l][EXTENT_BITS-1:0]
			                          : shifted[l][EXTENT_BITS-1:0];
			nxt.lane[l].dvd = {in_cell.lane[l].dvd[DVD_W-2:0], 1'b0};
			nxt.lane[l].quo = {in_cell.lane[l].quo[DVD_W-2:0], take[l]};
		end
	end

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_cell  = cell_q;

endmodule

>>> rtl/afc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_back: rounding and result assembly
// Rounds each quotient half up, then applies the minimum of one, the range
// check, scale saturation and the centring offsets.
// ----------------------------------------------------------------------------
module afc_back
	import afc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  cell_t in_cell,
	output logic  out_valid,
	output res_t  out_res
);

	localparam int SX_W = (QR_W > SCALE_W) ? QR_W : SCALE_W + 1;

	logic  valid_s1;
	side_t side_s1;
	logic [QR_W-1:0] qr_s1 [NUM_LANES];
	logic [QR_W-1:0] qr_c  [NUM_LANES];

	logic [QR_W-1:0] w_val, h_val;
	logic            w_big, h_big;
	logic [SX_W-1:0] sx;
	logic [EXTENT_BITS:0] dw, dh;
	res_t res;

	// round half up: remainder at least half the divisor
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			qr_c[l] = {1'b0, in_cell.lane[l].quo} +
				QR_W'({in_cell.lane[l].rem, 1'b0} >= {1'b0, in_cell.lane[l].dsr});
		end
	end

	// valid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// rounded quotients
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_cell.side;
			for (int l = 0; l < NUM_LANES; l++) begin
				qr_s1[l] <= qr_c[l];
			end
		end
	end

	// result selection
	always_comb begin
		w_val = (qr_s1[LANE_W] == '0) ? QR_W'(1) : qr_s1[LANE_W];
		h_val = (qr_s1[LANE_H] == '0) ? QR_W'(1) : qr_s1[LANE_H];
		w_big = |w_val[QR_W-1:EXTENT_BITS];
		h_big = |h_val[QR_W-1:EXTENT_BITS];
		sx    = SX_W'(qr_s1[LANE_S]);
		dw    = {1'b0, side_s1.bw} - {1'b0, w_val[EXTENT_BITS-1:0]};
		dh    = {1'b0, side_s1.bh} - {1'b0, h_val[EXTENT_BITS-1:0]};

		res = '0;
		if (!side_s1.func_ok) begin
			res = '0;
		end else if (side_s1.status != ST_OK) begin
			res.status = side_s1.status;
		end else if ((side_s1.func == FN_WFH) || (side_s1.func == FN_HFW)) begin
			if (w_big)
				res.status = ST_RANGE;
			else if (side_s1.func == FN_WFH)
				res.out_width = w_val[EXTENT_BITS-1:0];
			else
				res.out_height = w_val[EXTENT_BITS-1:0];
		end else if ((side_s1.func != FN_SCALE) && (w_big || h_big)) begin
			res.status = ST_RANGE;
		end else begin
			res.scale = (sx > SX_W'({SCALE_W{1'b1}})) ? {SCALE_W{1'b1}}
			                                          : sx[SCALE_W-1:0];
			if (side_s1.func != FN_SCALE) begin
				res.out_width  = w_val[EXTENT_BITS-1:0];
				res.out_height = h_val[EXTENT_BITS-1:0];
			end
			if (side_s1.func == FN_RECT) begin
				res.offset_x = dw[EXTENT_BITS] ? '0 : dw[EXTENT_BITS-1:1];
				res.offset_y = dh[EXTENT_BITS] ? '0 : dh[EXTENT_BITS-1:1];
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_res   = res;

endmodule

>>> rtl/aspect_fit_contain.sv
`timescale 1ns / 1ps
// pipeline: a request accepted into the first front stage passes front stages
// 2 to 4, 32 divider cells, the rounding stage and the output register before
// m_axis_tvalid shows its result; throughput: one request per cycle while the
// skid slot is empty, set by the divider cell chain taking one quotient bit per
// cell on three lanes in parallel.
// reset: arst_n clears all valid flags and the output skid; no clearing pass.
// ----------------------------------------------------------------------------
// aspect_fit_contain: letterbox fit unit
// Computes contain scale, fitted size, centred rectangle and ratio-kept
// lengths through a chain of restoring divider cells behind a skid output.
// ----------------------------------------------------------------------------
module aspect_fit_contain
	import afc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// src_width, src_height, bound_width, bound_height, allow_upscale,
	// given_length, zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// func, zero fill
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// scale_q16, out_width, out_height, offset_x, offset_y, zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status, zero fill
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	localparam int E = EXTENT_BITS;

	logic  en;
	req_t  req;
	logic  chain_v [NUM_CELLS+1];
	cell_t chain_d [NUM_CELLS+1];
	logic  back_valid;
	res_t  back_res;
	logic  push;

	logic  out_valid_q, skid_valid_q;
	res_t  out_res_q, skid_res_q;

	// pipeline moves while the skid slot is free
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	// unpack the request transfer
	always_comb begin
		req.func = s_axis_tuser[FUNC_W-1:0];
		req.sw   = s_axis_tdata[E-1:0];
		req.sh   = s_axis_tdata[2*E-1:E];
		req.bw   = s_axis_tdata[3*E-1:2*E];
		req.bh   = s_axis_tdata[4*E-1:3*E];
		req.up   = s_axis_tdata[4*E];
		req.g    = s_axis_tdata[5*E:4*E+1];
	end

	afc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_req    (req),
		.out_valid (chain_v[0]),
		.out_cell  (chain_d[0])
	);

	// divider cell chain
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		afc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[k]),
			.in_cell   (chain_d[k]),
			.out_valid (chain_v[k+1]),
			.out_cell  (chain_d[k+1])
		);
	end

	afc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (chain_v[NUM_CELLS]),
		.in_cell   (chain_d[NUM_CELLS]),
		.out_valid (back_valid),
		.out_res   (back_res)
	);

	assign push = back_valid && en;

	// output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_axis_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_valid_q) begin
			out_res_q <= skid_valid_q ? skid_res_q : back_res;
		end else if (push) begin
			skid_res_q <= back_res;
		end
	end

	// pack the result transfer
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_res_q.offset_y, out_res_q.offset_x,
		out_res_q.out_height, out_res_q.out_width, out_res_q.scale});
	assign m_axis_tuser  = OUT_USER_W'(out_res_q.status);

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the aspect fit contain unit
// Streams fit requests of all five operations and the unused selectors
// through the block under bursty input and a stalling output. It predicts
// each result with exact integer arithmetic and compares every field in order.
// ----------------------------------------------------------------------------
module testbench;
	import afc_pkg::*;

	// selector values with no operation behind them
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

	localparam logic [63:0] EXT_LIMIT   = (64'd1 << EXTENT_BITS) - 64'd1;
	localparam logic [63:0] SCALE_LIMIT = (64'd1 << SCALE_W) - 64'd1;
	localparam int          RANDOM_REQS = 1200;
	localparam int          STALL_LIMIT = 5000;
	localparam int          DRAIN_WAIT  = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	req_t fit_requests[$];
	res_t fit_results_due[$];

	int mismatches = 0;
	int results_seen = 0;
	int func_count[8];
	int status_count[4];
	int idle_cycles = 0;

	aspect_fit_contain u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quotient rounded half up
	function automatic logic [63:0] div_half_up(input logic [63:0] p, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = p / d;
		r = p % d;
		if (r >= d - r)
			q = q + 64'd1;
		return q;
	endfunction

	// ratio as unsigned fixed point, rounded half up, saturating
	function automatic logic [63:0] ratio_fixed(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		q = div_half_up(num << SCALE_FRAC_BITS, den);
		return (q > SCALE_LIMIT) ? SCALE_LIMIT : q;
	endfunction

	// expected result of one fit request
	function automatic res_t contain_fit(input req_t r);
		res_t        o;
		logic [63:0] sw, sh, bw, bh, g, num, den, w, h, v;
		logic        up;
		o  = '0;
		sw = 64'(r.sw);
		sh = 64'(r.sh);
		bw = 64'(r.bw);
		bh = 64'(r.bh);
		g  = 64'(r.g);
		w  = 64'd0;
		h  = 64'd0;
		if (r.func > FN_HFW)
			return o;
		if (sw == 64'd0 || sh == 64'd0) begin
			o.status = ST_ZERO_SRC;
			return o;
		end
		// ratio-kept length
		if (r.func == FN_WFH || r.func == FN_HFW) begin
			v = (r.func == FN_WFH) ? div_half_up(g * sw, sh) : div_half_up(g * sh, sw);
			if (v < 64'd1)
				v = 64'd1;
			if (v > EXT_LIMIT) begin
				o.status = ST_RANGE;
				return o;
			end
			if (r.func == FN_WFH)
				o.out_width = v[EXTENT_BITS-1:0];
			else
				o.out_height = v[EXTENT_BITS-1:0];
			return o;
		end
		if (bw == 64'd0 || bh == 64'd0) begin
			o.status = ST_ZERO_BOUND;
			return o;
		end
		up = r.up || (r.func == FN_RECT);
		// tighter of the two ratios
		if (bw * sh <= bh * sw) begin
			num = bw;
			den = sw;
		end else begin
			num = bh;
			den = sh;
		end
		if (!up && num > den) begin
			num = 64'd1;
			den = 64'd1;
		end
		// fitted sides
		if (r.func != FN_SCALE) begin
			w = div_half_up(sw * num, den);
			h = div_half_up(sh * num, den);
			if (w < 64'd1)
				w = 64'd1;
			if (h < 64'd1)
				h = 64'd1;
			if (w > EXT_LIMIT || h > EXT_LIMIT) begin
				o.status = ST_RANGE;
				return o;
			end
		end
		o.scale      = SCALE_W'(ratio_fixed(num, den));
		o.out_width  = w[EXTENT_BITS-1:0];
		o.out_height = h[EXTENT_BITS-1:0];
		// centring offsets
		if (r.func == FN_RECT) begin
			o.offset_x = (bw >= w) ? OFS_W'((bw - w) >> 1) : '0;
			o.offset_y = (bh >= h) ? OFS_W'((bh - h) >> 1) : '0;
		end
		return o;
	endfunction

	task automatic queue_fit(input logic [FUNC_W-1:0] func, input int sw, input int sh,
			input int bw, input int bh, input logic up, input int g);
		req_t r;
		r.func = func;
		r.sw   = ext_t'(sw);
		r.sh   = ext_t'(sh);
		r.bw   = ext_t'(bw);
		r.bh   = ext_t'(bh);
		r.up   = up;
		r.g    = ext_t'(g);
		fit_requests.push_back(r);
	endtask

	// extents weighted toward small sizes, with zeros and extremes mixed in
	function automatic ext_t pick_extent();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return '0;
		else if (roll < 13) begin
			case ($urandom_range(0, 3))
				0: return ext_t'(1);
				1: return '1;
				2: return ext_t'(16'hFFFE);
				default: return ext_t'(16'h8000);
			endcase
		end else if (roll < 50)
			return ext_t'($urandom_range(1, 64));
		else if (roll < 80)
			return ext_t'($urandom_range(1, 4096));
		else
			return ext_t'($urandom);
	endfunction

	function automatic req_t random_fit();
		req_t r;
		r.func = ($urandom_range(0, 9) == 0) ? FUNC_W'($urandom_range(5, 7))
			: FUNC_W'($urandom_range(0, 4));
		r.sw   = pick_extent();
		r.sh   = pick_extent();
		r.bw   = pick_extent();
		r.bh   = pick_extent();
		r.up   = 1'($urandom);
		r.g    = pick_extent();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: result %0d %s got %0h expected %0h", $time, results_seen, what,
			got, want);
		mismatches++;
	endtask

	// sender: bursts of transfers with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		req_t r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			burst_left    <= 1;
			gap_left      <= 0;
		end else begin
			// accepted transfer: predict and retire
			if (s_axis_tvalid && s_axis_tready) begin
				fit_results_due.push_back(contain_fit(fit_requests[0]));
				func_count[fit_requests[0].func]++;
				void'(fit_requests.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left      <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (fit_requests.size() != 0) begin
					r = fit_requests[0];
					s_axis_tdata  <= IN_DATA_W'({r.g, r.up, r.bh, r.bw, r.sh, r.sw});
					s_axis_tuser  <= IN_USER_W'(r.func);
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern chosen by bits 9:8 of a free-running cycle counter
	logic [15:0] rx_cycle = '0;
	always @(posedge clk or negedge arst_n) begin
		res_t seen;
		res_t due;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_cycle      <= '0;
		end else begin
			rx_cycle <= rx_cycle + 16'd1;
			case (rx_cycle[9:8])
				2'd0: m_axis_tready <= 1'b1;
				2'd1: m_axis_tready <= (rx_cycle[1:0] == 2'd0);
				2'd2: m_axis_tready <= 1'($urandom);
				default: m_axis_tready <= (rx_cycle[4:3] != 2'd0);
			endcase
			// compare a result transfer with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				seen.status     = m_axis_tuser[STATUS_W-1:0];
				seen.scale      = m_axis_tdata[SCALE_W-1:0];
				seen.out_width  = m_axis_tdata[SCALE_W +: EXTENT_BITS];
				seen.out_height = m_axis_tdata[SCALE_W+EXTENT_BITS +: EXTENT_BITS];
				seen.offset_x   = m_axis_tdata[SCALE_W+2*EXTENT_BITS +: OFS_W];
				seen.offset_y   = m_axis_tdata[SCALE_W+2*EXTENT_BITS+OFS_W +: OFS_W];
				status_count[seen.status]++;
				if (fit_results_due.size() == 0) begin
					report_mismatch("unexpected, status", 64'(seen.status), 64'd0);
				end else begin
					due = fit_results_due.pop_front();
					if (seen.status != due.status)
						report_mismatch("status", 64'(seen.status), 64'(due.status));
					if (seen.scale != due.scale)
						report_mismatch("scale", 64'(seen.scale), 64'(due.scale));
					if (seen.out_width != due.out_width)
						report_mismatch("out_width", 64'(seen.out_width), 64'(due.out_width));
					if (seen.out_height != due.out_height)
						report_mismatch("out_height", 64'(seen.out_height), 64'(due.out_height));
					if (seen.offset_x != due.offset_x)
						report_mismatch("offset_x", 64'(seen.offset_x), 64'(due.offset_x));
					if (seen.offset_y != due.offset_y)
						report_mismatch("offset_y", 64'(seen.offset_y), 64'(due.offset_y));
				end
				results_seen++;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d results outstanding", idle_cycles,
				fit_results_due.size());
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic wait_drained();
		while (fit_requests.size() != 0 || s_axis_tvalid || fit_results_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		// directed: typical fits, caps, extremes and error cases
		queue_fit(FN_SCALE, 1920, 1080, 1280, 720, 1'b0, 0);
		queue_fit(FN_SCALE, 100, 50, 400, 400, 1'b0, 0);
		queue_fit(FN_SCALE, 100, 50, 400, 400, 1'b1, 0);
		queue_fit(FN_SCALE, 1, 1, 65535, 65535, 1'b1, 0);
		queue_fit(FN_SCALE, 65535, 65535, 1, 1, 1'b0, 0);
		queue_fit(FN_SIZE, 1920, 1080, 1000, 1000, 1'b0, 0);
		queue_fit(FN_SIZE, 65535, 1, 1, 65535, 1'b1, 0);
		queue_fit(FN_SIZE, 4, 3, 400, 300, 1'b1, 0);
		queue_fit(FN_RECT, 1920, 1080, 1024, 768, 1'b0, 0);
		queue_fit(FN_RECT, 16, 9, 65535, 65535, 1'b0, 0);
		queue_fit(FN_RECT, 9, 16, 1920, 1080, 1'b1, 0);
		queue_fit(FN_RECT, 65535, 65535, 65535, 65535, 1'b1, 65535);
		queue_fit(FN_WFH, 16, 9, 0, 0, 1'b0, 1080);
		queue_fit(FN_WFH, 65535, 1, 7, 7, 1'b1, 2);
		queue_fit(FN_WFH, 3, 2, 0, 0, 1'b0, 0);
		queue_fit(FN_HFW, 16, 9, 0, 0, 1'b0, 1920);
		queue_fit(FN_HFW, 65535, 1, 0, 0, 1'b0, 1);
		queue_fit(FN_HFW, 1, 1, 65535, 65535, 1'b1, 65535);
		queue_fit(FN_SIZE, 0, 480, 640, 480, 1'b0, 0);
		queue_fit(FN_WFH, 640, 0, 640, 480, 1'b0, 100);
		queue_fit(FN_SCALE, 640, 480, 0, 480, 1'b1, 0);
		queue_fit(FN_RECT, 640, 480, 640, 0, 1'b0, 0);
		queue_fit(FN_SPARE_A, 640, 480, 320, 240, 1'b1, 100);
		queue_fit(FN_SPARE_B, 65535, 65535, 65535, 65535, 1'b1, 65535);
		queue_fit(FN_SPARE_C, 1, 1, 1, 1, 1'b0, 1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// hold the sender until the directed results are all back
		wait_drained();
		for (int i = 0; i < RANDOM_REQS / 2; i++)
			fit_requests.push_back(random_fit());
		wait_drained();
		for (int i = RANDOM_REQS / 2; i < RANDOM_REQS; i++)
			fit_requests.push_back(random_fit());
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display(
			"requests: scale %0d, size %0d, rect %0d, wfh %0d, hfw %0d, unused %0d",
			func_count[FN_SCALE], func_count[FN_SIZE], func_count[FN_RECT],
			func_count[FN_WFH], func_count[FN_HFW],
			func_count[FN_SPARE_A] + func_count[FN_SPARE_B] + func_count[FN_SPARE_C]);
		$display(
			"results: %0d checked, ok %0d, zero source %0d, zero bounds %0d, range %0d",
			results_seen, status_count[ST_OK], status_count[ST_ZERO_SRC],
			status_count[ST_ZERO_BOUND], status_count[ST_RANGE]);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
